// ----- src/tun_pkg.sv -----
// Shared types and widths for the triangle unit normal block.
// Used by tun_front, tun_cell and triangle_unit_normal; no dependencies.
package tun_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int OUT_W      = 16;

  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ACC_W   = SUM_W + 2 * FRAC_BITS + 6;
  localparam int K_W     = FRAC_BITS + 1;
  localparam int BIT_W   = $clog2(FRAC_BITS + 1);
  localparam int SH_W    = BIT_W + 2;
  localparam int T_SHIFT = 2 * FRAC_BITS + 2;
  localparam int NCELL   = FRAC_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]     edge_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;
  typedef logic [MAG_W-1:0]             mag_t;
  typedef logic [SQ_W-1:0]              sq_t;
  typedef logic [SUM_W-1:0]             sum_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic [K_W-1:0]               k_t;

  typedef struct packed {
    coord_t [2:0][2:0] v;
  } tri_t;

  typedef struct packed {
    acc_t d;
    acc_t p;
    k_t   k;
    logic neg;
  } lane_t;

  typedef struct packed {
    logic           valid;
    logic           degen;
    sum_t           s;
    lane_t [2:0]    lane;
  } cell_t;

endpackage

// ----- src/triangle_unit_normal.sv -----
// Top level: unit face normal of a triangle in signed Q1.14.
// Depends on tun_pkg, tun_front and tun_cell.
//
//   channel | ports                                  | direction
//   in      | in_valid, in_stall, in_v0_x .. in_v2_z | triangle words in
//   out     | out_valid, out_stall, out_normal_*,    | normal words out
//           | out_degenerate                         |
//
// One triangle per cycle while the output word is not stalled; the path is 6 front stages,
// FRAC_BITS+1 search cells and one output register.
// The search cells each settle one bit of the three components per cycle unless stalled.
// Reset clears only the valid bits.
// A stalled output word holds the whole pipeline; in_stall follows it.
module triangle_unit_normal (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  tun_pkg::coord_t         in_v0_x,
  input  tun_pkg::coord_t         in_v0_y,
  input  tun_pkg::coord_t         in_v0_z,
  input  tun_pkg::coord_t         in_v1_x,
  input  tun_pkg::coord_t         in_v1_y,
  input  tun_pkg::coord_t         in_v1_z,
  input  tun_pkg::coord_t         in_v2_x,
  input  tun_pkg::coord_t         in_v2_y,
  input  tun_pkg::coord_t         in_v2_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [tun_pkg::OUT_W-1:0] out_normal_x,
  output logic signed [tun_pkg::OUT_W-1:0] out_normal_y,
  output logic signed [tun_pkg::OUT_W-1:0] out_normal_z,
  output logic                    out_degenerate
);

  logic en;
  tun_pkg::tri_t  tri_w;
  tun_pkg::cell_t chain [tun_pkg::NCELL+1];
  tun_pkg::cell_t last;
  logic signed [tun_pkg::OUT_W:0]   q [3];
  logic signed [tun_pkg::OUT_W-1:0] n_nxt [3];
  logic out_valid_r;
  logic signed [tun_pkg::OUT_W-1:0] nx_r, ny_r, nz_r;
  logic degen_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign tri_w.v[0][0] = in_v0_x;
  assign tri_w.v[0][1] = in_v0_y;
  assign tri_w.v[0][2] = in_v0_z;
  assign tri_w.v[1][0] = in_v1_x;
  assign tri_w.v[1][1] = in_v1_y;
  assign tri_w.v[1][2] = in_v1_z;
  assign tri_w.v[2][0] = in_v2_x;
  assign tri_w.v[2][1] = in_v2_y;
  assign tri_w.v[2][2] = in_v2_z;

  tun_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .tri_in   (tri_w),
    .seed     (chain[0])
  );

  for (genvar j = 0; j < tun_pkg::NCELL; j++) begin : g_cell
    tun_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .bit_idx (tun_pkg::BIT_W'(tun_pkg::FRAC_BITS - j)),
      .cin     (chain[j]),
      .cout    (chain[j+1])
    );
  end

  assign last = chain[tun_pkg::NCELL];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = $signed({1'b0, tun_pkg::OUT_W'(last.lane[i].k)});
      if (last.lane[i].neg) begin
        q[i] = -q[i];
      end
      n_nxt[i] = last.degen ? '0 : q[i][tun_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r    <= n_nxt[0];
      ny_r    <= n_nxt[1];
      nz_r    <= n_nxt[2];
      degen_r <= last.degen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = nx_r;
  assign out_normal_y   = ny_r;
  assign out_normal_z   = nz_r;
  assign out_degenerate = degen_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to held output word");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_normal_x == 0 && out_normal_y == 0
                                   && out_normal_z == 0)
    else $error("degenerate word carries a nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_x <= 16384 && out_normal_x >= -16384
                  && out_normal_y <= 16384 && out_normal_y >= -16384
                  && out_normal_z <= 16384 && out_normal_z >= -16384)
    else $error("normal component beyond unit range");

endmodule

// ----- src/tun_front.sv -----
// Front pipeline: edges, cross product, squares, squared length and search seed.
// Depends on tun_pkg.
module tun_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  tun_pkg::tri_t tri_in,
  output tun_pkg::cell_t seed
);

  logic [4:0] vld_r;
  tun_pkg::edge_t  [2:0] e1_r, e2_r;
  tun_pkg::prod_t  [5:0] prod_r;
  tun_pkg::mag_t   [2:0] mag_r;
  logic            [2:0] neg3_r, neg4_r, neg5_r;
  tun_pkg::sq_t    [2:0] sq_r, sq5_r;
  tun_pkg::sum_t         s_r;
  tun_pkg::cross_t [2:0] c_nxt;
  tun_pkg::cell_t        seed_r, seed_nxt;

  always_comb begin
    c_nxt[0] = tun_pkg::cross_t'(prod_r[0]) - tun_pkg::cross_t'(prod_r[1]);
    c_nxt[1] = tun_pkg::cross_t'(prod_r[2]) - tun_pkg::cross_t'(prod_r[3]);
    c_nxt[2] = tun_pkg::cross_t'(prod_r[4]) - tun_pkg::cross_t'(prod_r[5]);
    seed_nxt.valid = vld_r[4];
    seed_nxt.degen = (s_r == '0);
    seed_nxt.s     = s_r;
    for (int i = 0; i < 3; i++) begin
      seed_nxt.lane[i].d   = (tun_pkg::acc_t'(sq5_r[i]) <<< tun_pkg::T_SHIFT)
                             - tun_pkg::acc_t'(s_r);
      seed_nxt.lane[i].p   = -tun_pkg::acc_t'(s_r);
      seed_nxt.lane[i].k   = '0;
      seed_nxt.lane[i].neg = neg5_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      seed_r.valid <= 1'b0;
    end else if (en) begin
      vld_r  <= {vld_r[3:0], in_valid};
      seed_r <= seed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        e1_r[a] <= tun_pkg::edge_t'(tri_in.v[1][a]) - tun_pkg::edge_t'(tri_in.v[0][a]);
        e2_r[a] <= tun_pkg::edge_t'(tri_in.v[2][a]) - tun_pkg::edge_t'(tri_in.v[0][a]);
      end
      prod_r[0] <= tun_pkg::prod_t'(e1_r[1]) * tun_pkg::prod_t'(e2_r[2]);
      prod_r[1] <= tun_pkg::prod_t'(e1_r[2]) * tun_pkg::prod_t'(e2_r[1]);
      prod_r[2] <= tun_pkg::prod_t'(e1_r[2]) * tun_pkg::prod_t'(e2_r[0]);
      prod_r[3] <= tun_pkg::prod_t'(e1_r[0]) * tun_pkg::prod_t'(e2_r[2]);
      prod_r[4] <= tun_pkg::prod_t'(e1_r[0]) * tun_pkg::prod_t'(e2_r[1]);
      prod_r[5] <= tun_pkg::prod_t'(e1_r[1]) * tun_pkg::prod_t'(e2_r[0]);
      for (int i = 0; i < 3; i++) begin
        mag_r[i]  <= c_nxt[i][tun_pkg::CROSS_W-1] ? tun_pkg::mag_t'(-c_nxt[i])
                                                  : tun_pkg::mag_t'(c_nxt[i]);
        neg3_r[i] <= c_nxt[i][tun_pkg::CROSS_W-1];
        sq_r[i]   <= tun_pkg::sq_t'(mag_r[i]) * tun_pkg::sq_t'(mag_r[i]);
        neg4_r[i] <= neg3_r[i];
      end
      s_r   <= tun_pkg::sum_t'(sq_r[0]) + tun_pkg::sum_t'(sq_r[1])
               + tun_pkg::sum_t'(sq_r[2]);
      sq5_r <= sq_r;
      neg5_r <= neg4_r;
    end
  end

  assign seed = seed_r;

endmodule

// ----- src/tun_cell.sv -----
// One cell of the search chain: settles one bit of the scaled component for all
// three lanes and hands the word on. Depends on tun_pkg.
module tun_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic [tun_pkg::BIT_W-1:0] bit_idx,
  input  tun_pkg::cell_t           cin,
  output tun_pkg::cell_t           cout
);

  tun_pkg::cell_t cell_r, cell_nxt;
  logic [tun_pkg::SH_W-1:0] sh_p, sh_s, sh_u;
  tun_pkg::acc_t s_w;
  tun_pkg::acc_t inc [3];

  always_comb begin
    sh_p = tun_pkg::SH_W'(bit_idx) + tun_pkg::SH_W'(2);
    sh_s = tun_pkg::SH_W'({bit_idx, 1'b0}) + tun_pkg::SH_W'(2);
    sh_u = tun_pkg::SH_W'(bit_idx) + tun_pkg::SH_W'(1);
    s_w  = tun_pkg::acc_t'(cin.s);
    cell_nxt = cin;
    for (int i = 0; i < 3; i++) begin
      inc[i] = (cin.lane[i].p <<< sh_p) + (s_w <<< sh_s);
      if (inc[i] <= cin.lane[i].d) begin
        cell_nxt.lane[i].d = cin.lane[i].d - inc[i];
        cell_nxt.lane[i].p = cin.lane[i].p + (s_w <<< sh_u);
        cell_nxt.lane[i].k = cin.lane[i].k | (tun_pkg::k_t'(1) << bit_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cout = cell_r;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench for triangle_unit_normal: random and corner triangles in,
// unit normals checked against an exact integer rounding of the cross product.
// Depends on tun_pkg and the triangle_unit_normal RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] v [9];
  } tri_word_t;

  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic               degen;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tun_pkg::coord_t in_v [9];
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [tun_pkg::OUT_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_degenerate;
  logic in_accept_q = 1'b0;

  tri_word_t pending_tris[$];
  normal_t   normals_due[$];
  int  send_idle_pct = 0, recv_idle_pct = 0;
  int  hold_cycles = 0;
  int  fail_cnt = 0, checked_cnt = 0, degen_cnt = 0, quiet_cycles = 0;

  initial foreach (in_v[i]) in_v[i] = '0;

  triangle_unit_normal dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_v0_x(in_v[0]), .in_v0_y(in_v[1]), .in_v0_z(in_v[2]),
    .in_v1_x(in_v[3]), .in_v1_y(in_v[4]), .in_v1_z(in_v[5]),
    .in_v2_x(in_v[6]), .in_v2_y(in_v[7]), .in_v2_z(in_v[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z), .out_degenerate(out_degenerate)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // largest k in [0, 2^FRAC] with (2k-1)^2 * s <= 4 c^2 4^FRAC
  function automatic logic [15:0] round_component(longint signed c, logic [127:0] s);
    logic [127:0] target, p;
    logic [63:0]  cm, lo, hi, mid, odd;
    cm = (c < 0) ? -c : c;
    target = ({64'd0, cm} * cm) << (2 * tun_pkg::FRAC_BITS + 2);
    lo = 0;
    hi = 64'd1 << tun_pkg::FRAC_BITS;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      odd = 2 * mid - 1;
      p = ({64'd0, odd} * odd) * s;
      if (p <= target) lo = mid;
      else hi = mid - 1;
    end
    if (c < 0) lo = -lo;
    return lo[15:0];
  endfunction

  function automatic normal_t face_normal(tri_word_t t);
    longint signed e1 [3], e2 [3], c [3];
    logic [127:0] s;
    normal_t r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(t.v[3+i]) - longint'(t.v[i]);
      e2[i] = longint'(t.v[6+i]) - longint'(t.v[i]);
    end
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    s = 0;
    for (int i = 0; i < 3; i++) begin
      logic [63:0] m;
      m = (c[i] < 0) ? -c[i] : c[i];
      s += {64'd0, m} * m;
    end
    if (s == 0) begin
      r.nx = 0; r.ny = 0; r.nz = 0; r.degen = 1'b1;
    end else begin
      r.nx = round_component(c[0], s);
      r.ny = round_component(c[1], s);
      r.nz = round_component(c[2], s);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    in_accept_q <= in_valid && !in_stall;
  end

  // driver: advance on acceptance, hold payload while stalled
  always @(negedge clk) begin
    if (rst_n && in_accept_q) begin
      if (pending_tris.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        tri_word_t t;
        t = pending_tris.pop_front();
        foreach (in_v[i]) in_v[i] <= t.v[i];
      end else begin
        in_valid <= 1'b0;
      end
    end else if (rst_n && !in_valid && pending_tris.size() > 0 &&
                 $urandom_range(99) >= send_idle_pct) begin
      tri_word_t t;
      t = pending_tris.pop_front();
      foreach (in_v[i]) in_v[i] <= t.v[i];
      in_valid <= 1'b1;
    end
  end

  // receiver: random idling, and a long hold at the start of the last phase
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // predictor on input acceptance, check on output acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_valid && !in_stall) begin
        tri_word_t t;
        foreach (in_v[i]) t.v[i] = in_v[i];
        normals_due.push_back(face_normal(t));
      end
      if (out_valid && !out_stall) begin
        if (normals_due.size() == 0) begin
          $error("normal word with no triangle pending");
          fail_cnt++;
        end else begin
          normal_t e;
          e = normals_due.pop_front();
          checked_cnt++;
          if (e.degen) degen_cnt++;
          if (out_normal_x !== e.nx) begin
            $error("normal_x exp %0d got %0d", e.nx, out_normal_x); fail_cnt++;
          end
          if (out_normal_y !== e.ny) begin
            $error("normal_y exp %0d got %0d", e.ny, out_normal_y); fail_cnt++;
          end
          if (out_normal_z !== e.nz) begin
            $error("normal_z exp %0d got %0d", e.nz, out_normal_z); fail_cnt++;
          end
          if (out_degenerate !== e.degen) begin
            $error("degenerate exp %0b got %0b", e.degen, out_degenerate); fail_cnt++;
          end
        end
      end
      if (quiet_cycles > 5000) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("[triangle_unit_normal] ERROR");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom_range(65535));
      1: return 16'($signed(16'($urandom_range(31))) - 16);
      2: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
      default: return 16'(int'($urandom_range(1023)) - 512);
    endcase
  endfunction

  task automatic queue_tri(logic signed [15:0] a [9]);
    tri_word_t t;
    foreach (a[i]) t.v[i] = a[i];
    pending_tris.push_back(t);
  endtask

  task automatic queue_random(int n);
    logic signed [15:0] a [9];
    for (int k = 0; k < n; k++) begin
      int mode;
      mode = $urandom_range(3);
      foreach (a[i]) a[i] = rand_coord(mode);
      case ($urandom_range(9))
        0: for (int i = 3; i < 9; i++) a[i] = a[i % 3];
        1: for (int i = 0; i < 3; i++) a[6+i] = 16'(a[i] + 2 * (a[3+i] - a[i]));
        default: ;
      endcase
      queue_tri(a);
    end
  endtask

  task automatic drain();
    while (pending_tris.size() > 0 || in_valid || normals_due.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] a [9];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 26; recv_idle_pct = 61;
    a = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; queue_tri(a);
    a = '{0, 0, 0, 0, 1, 0, 1, 0, 0}; queue_tri(a);
    a = '{0, 0, 0, 0, 0, 1, 1, 0, 0}; queue_tri(a);
    a = '{0, 0, 0, 1, 1, 0, 1, 0, 1}; queue_tri(a);
    a = '{5, 5, 5, 5, 5, 5, 5, 5, 5}; queue_tri(a);
    a = '{0, 0, 0, 1, 1, 1, 2, 2, 2}; queue_tri(a);
    a = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
    queue_tri(a);
    a = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
    queue_tri(a);
    a = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767};
    queue_tri(a);
    a = '{0, 0, 0, 1, 2, 0, 2, 1, 0}; queue_tri(a);
    a = '{0, 0, 0, 3, 0, 0, 0, 4, 7}; queue_tri(a);
    a = '{-1, -1, -1, -1, -1, -1, 0, 0, 0}; queue_tri(a);
    queue_random(240);
    drain();

    send_idle_pct = 61; recv_idle_pct = 26;
    queue_random(250);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    queue_random(250);
    hold_cycles = 200;
    drain();

    $display("checked %0d normals (%0d degenerate) across three idle mixes",
             checked_cnt, degen_cnt);
    if (fail_cnt == 0) $display("[triangle_unit_normal] OK");
    else $display("[triangle_unit_normal] ERROR");
    $finish;
  end
endmodule
